/* rtl/rmfrb_pkg.sv */
// Package for the register-mapped flash row buffer.
// Register map codes, command codes, internal op codes and the queue entry type.
// No dependencies; every file but rmfrb_if.sv imports it.
package rmfrb_pkg;

   // access kinds
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // register map
   localparam logic [7:0] REG_BOARD   = 8'h00;
   localparam logic [7:0] REG_FW      = 8'h01;
   localparam logic [7:0] REG_HW      = 8'h02;
   localparam logic [7:0] REG_CMD     = 8'h1d;
   localparam logic [7:0] REG_BASE_LO = 8'h1e;
   localparam logic [7:0] REG_BASE_HI = 8'h1f;
   localparam logic [7:0] REG_WINDOW  = 8'h20;

   // command register values
   localparam logic [7:0] CMD_LOAD  = 8'd1;
   localparam logic [7:0] CMD_STORE = 8'd2;

   // csr indexes and reset values
   localparam logic [7:0] CSR_BOARD_KIND       = 8'd0;
   localparam logic [7:0] CSR_FIRMWARE_VERSION = 8'd1;
   localparam logic [7:0] CSR_HARDWARE_VERSION = 8'd2;
   localparam logic [7:0] BOARD_KIND_RESET       = 8'd3;
   localparam logic [7:0] FIRMWARE_VERSION_RESET = 8'd5;
   localparam logic [7:0] HARDWARE_VERSION_RESET = 8'd1;

   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   // decoded operations handed from front to back
   typedef logic [3:0] op_type;
   localparam op_type OP_RD_VALUE   = 4'd0;
   localparam op_type OP_RD_CMD     = 4'd1;
   localparam op_type OP_RD_BASE_LO = 4'd2;
   localparam op_type OP_RD_BASE_HI = 4'd3;
   localparam op_type OP_RD_WIN     = 4'd4;
   localparam op_type OP_WR_CMD     = 4'd5;
   localparam op_type OP_WR_BASE_LO = 4'd6;
   localparam op_type OP_WR_BASE_HI = 4'd7;
   localparam op_type OP_WR_WIN     = 4'd8;
   localparam op_type OP_BAD        = 4'd9;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;    // write byte, or resolved read value
      logic [7:0] offset;  // window offset
   } item_type;

   localparam int QUEUE_DEPTH = 2;

endpackage

/* rtl/rmfrb_if.sv */
// Channel interfaces: register access requests, responses and csr writes.
// Plain valid/ready channels; no dependencies.
interface rmfrb_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] reg_address;
   logic [7:0] write_data;
   modport source (output valid, req_type, reg_address, write_data, input ready);
   modport sink   (input valid, req_type, reg_address, write_data, output ready);
endinterface

interface rmfrb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       access_error;
   modport source (output valid, read_data, access_error, input ready);
   modport sink   (input valid, read_data, access_error, output ready);
endinterface

interface rmfrb_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

/* rtl/register_mapped_flash_row_buffer.sv */
// Byte-wide register map in front of a flash row window. After reset the flash array
// is swept to 0xFF before the first item is accepted.
// Simple register accesses: registered response, one per cycle while the receiver takes
// responses; a window read adds a window read state. Load/store command: queue, row
// setup, a one-byte-per-cycle copy through the window and flash ports, drain, done, response.
// Reset is synchronous, active high; csr registers return to their defaults.
module register_mapped_flash_row_buffer #(
   parameter int ROW_BYTES   = 32,
   parameter int FLASH_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   rmfrb_req_if.sink   req_chan,
   rmfrb_rsp_if.source rsp_chan,
   rmfrb_csr_if.sink   csr_chan
);
   import rmfrb_pkg::*;

   // front -> queue
   logic     push_valid;
   item_type push_item;
   logic     queue_full;
   // queue -> back
   logic     q_valid;
   item_type q_item;
   logic     pop;
   // back holds off the front while flash is being erased
   logic     clearing;

   // decode of each item and csr storage
   rmfrb_front #(
      .ROW_BYTES (ROW_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .clearing   (clearing),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // short queue lets front keep taking items while back copies a row
   rmfrb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop        (pop)
   );

   // executes items, owns window, flash and the response register
   rmfrb_back #(
      .ROW_BYTES   (ROW_BYTES),
      .FLASH_BYTES (FLASH_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .pop      (pop),
      .clearing (clearing),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/rmfrb_front.sv */
// Front end: csr registers, request accept and register decode.
// Uses rmfrb_pkg and the channel interfaces; pushes decoded items to rmfrb_queue.
module rmfrb_front #(
   parameter int ROW_BYTES = 32
) (
   input  logic                clock,
   input  logic                reset,
   rmfrb_req_if.sink           req_chan,
   rmfrb_csr_if.sink           csr_chan,
   input  logic                clearing,
   input  logic                queue_full,
   output logic                push_valid,
   output rmfrb_pkg::item_type push_item
);
   import rmfrb_pkg::*;

   logic [7:0] board_kind_ff, board_kind_in;
   logic [7:0] fw_ver_ff, fw_ver_in;
   logic [7:0] hw_ver_ff, hw_ver_in;
   logic       in_window;

   always_comb begin
      board_kind_in = board_kind_ff;
      fw_ver_in     = fw_ver_ff;
      hw_ver_in     = hw_ver_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_BOARD_KIND:       board_kind_in = csr_chan.wdata;
            CSR_FIRMWARE_VERSION: fw_ver_in     = csr_chan.wdata;
            CSR_HARDWARE_VERSION: hw_ver_in     = csr_chan.wdata;
            default:              ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_kind_ff <= BOARD_KIND_RESET;
         fw_ver_ff     <= FIRMWARE_VERSION_RESET;
         hw_ver_ff     <= HARDWARE_VERSION_RESET;
      end else begin
         board_kind_ff <= board_kind_in;
         fw_ver_ff     <= fw_ver_in;
         hw_ver_ff     <= hw_ver_in;
      end
   end

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !queue_full && !clearing;
   assign push_valid     = req_chan.valid && req_chan.ready;

   assign in_window = ({1'b0, req_chan.reg_address} >= {1'b0, REG_WINDOW}) &&
                      ({1'b0, req_chan.reg_address} < ({1'b0, REG_WINDOW} + 9'(ROW_BYTES)));

   always_comb begin
      push_item.data   = req_chan.write_data;
      push_item.offset = req_chan.reg_address - REG_WINDOW;
      push_item.op     = OP_BAD;
      if (req_chan.req_type == REQ_WRITE) begin
         case (req_chan.reg_address)
            REG_CMD:     push_item.op = OP_WR_CMD;
            REG_BASE_LO: push_item.op = OP_WR_BASE_LO;
            REG_BASE_HI: push_item.op = OP_WR_BASE_HI;
            default:     push_item.op = in_window ? OP_WR_WIN : OP_BAD;
         endcase
      end else begin
         case (req_chan.reg_address)
            REG_BOARD: begin
               push_item.op   = OP_RD_VALUE;
               push_item.data = board_kind_ff;
            end
            REG_FW: begin
               push_item.op   = OP_RD_VALUE;
               push_item.data = fw_ver_ff;
            end
            REG_HW: begin
               push_item.op   = OP_RD_VALUE;
               push_item.data = hw_ver_ff;
            end
            REG_CMD:     push_item.op = OP_RD_CMD;
            REG_BASE_LO: push_item.op = OP_RD_BASE_LO;
            REG_BASE_HI: push_item.op = OP_RD_BASE_HI;
            default:     push_item.op = in_window ? OP_RD_WIN : OP_BAD;
         endcase
      end
   end

endmodule

/* rtl/rmfrb_queue.sv */
// Two-entry queue of decoded items between front and back.
// Uses rmfrb_pkg for the entry type and depth.
module rmfrb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  rmfrb_pkg::item_type push_item,
   output logic                full,
   output logic                pop_valid,
   output rmfrb_pkg::item_type pop_item,
   input  logic                pop
);
   import rmfrb_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/rmfrb_back.sv */
// Back end: register state, row window, flash array, load/store sequencer,
// response register. Uses rmfrb_pkg and rmfrb_rsp_if; fed from rmfrb_queue.
module rmfrb_back #(
   parameter int ROW_BYTES   = 32,
   parameter int FLASH_BYTES = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  rmfrb_pkg::item_type q_item,
   output logic                pop,
   output logic                clearing,
   rmfrb_rsp_if.source         rsp_chan
);
   import rmfrb_pkg::*;

   localparam int FA_W  = $clog2(FLASH_BYTES);
   localparam int IDX_W = $clog2(ROW_BYTES);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_WIN_RD = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_LOAD   = 3'd4;
   localparam logic [2:0] S_STORE  = 3'd5;
   localparam logic [2:0] S_DRAIN  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [FA_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [7:0]       base_lo_ff, base_lo_in;
   logic [7:0]       base_hi_ff, base_hi_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic             is_load_ff, is_load_in;
   logic [FA_W:0]    addr_ff, addr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [FA_W-1:0]  pend_addr_ff, pend_addr_in;
   logic             pend_oob_ff, pend_oob_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_err_ff, rsp_err_in;

   // row window: memory plus per-entry valid bits (invalid reads as zero)
   logic [7:0]          win_mem [ROW_BYTES];
   logic [ROW_BYTES-1:0] win_vld_ff;
   logic [7:0]          win_rd_ff;
   logic                win_rd_vld_ff;
   logic                win_we, win_re;
   logic [IDX_W-1:0]    win_waddr, win_raddr;
   logic [7:0]          win_wdata, win_q;

   // flash array, swept to erased after reset
   logic [7:0]          flash_mem [FLASH_BYTES];
   logic [7:0]          flash_rd_ff;
   logic                flash_we, flash_re;
   logic [FA_W-1:0]     flash_waddr, flash_raddr;
   logic [7:0]          flash_wdata;

   logic [15:0]         base;
   logic [FA_W-1:0]     base_fa;
   logic                base_ok, cmd_ok, out_free, addr_oob;

   assign base     = {base_hi_ff, base_lo_ff};
   assign base_fa  = base[FA_W-1:0];
   assign base_ok  = {1'b0, base} < 17'(FLASH_BYTES);
   assign cmd_ok   = (q_item.data == CMD_LOAD) || (q_item.data == CMD_STORE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign addr_oob = addr_ff >= (FA_W+1)'(FLASH_BYTES);
   assign win_q    = win_rd_vld_ff ? win_rd_ff : 8'h00;
   assign clearing = (state_ff == S_CLEAR);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      base_lo_in   = base_lo_ff;
      base_hi_in   = base_hi_ff;
      cmd_in       = cmd_ff;
      is_load_in   = is_load_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      pend_addr_in = pend_addr_ff;
      pend_oob_in  = pend_oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      pop          = 1'b0;
      win_we       = 1'b0;
      win_waddr    = q_item.offset[IDX_W-1:0];
      win_wdata    = q_item.data;
      win_re       = 1'b0;
      win_raddr    = q_item.offset[IDX_W-1:0];
      flash_we     = 1'b0;
      flash_waddr  = clr_addr_ff;
      flash_wdata  = ERASED_BYTE;
      flash_re     = 1'b0;
      flash_raddr  = addr_ff[FA_W-1:0];

      case (state_ff)
         S_CLEAR: begin
            flash_we = 1'b1;
            if (clr_addr_ff == FA_W'(FLASH_BYTES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (q_valid && out_free) begin
               pop         = 1'b1;
               rsp_data_in = 8'h00;
               rsp_err_in  = 1'b0;
               case (q_item.op)
                  OP_RD_VALUE: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = q_item.data;
                  end
                  OP_RD_CMD: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = cmd_ff;
                  end
                  OP_RD_BASE_LO: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = base_lo_ff;
                  end
                  OP_RD_BASE_HI: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = base_hi_ff;
                  end
                  OP_RD_WIN: begin
                     win_re   = 1'b1;
                     state_in = S_WIN_RD;
                  end
                  OP_WR_CMD: begin
                     cmd_in = q_item.data;
                     if (cmd_ok && base_ok) begin
                        is_load_in = (q_item.data == CMD_LOAD);
                        state_in   = S_DIV;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_err_in   = 1'b1;
                     end
                  end
                  OP_WR_BASE_LO: begin
                     base_lo_in   = q_item.data;
                     rsp_valid_in = 1'b1;
                  end
                  OP_WR_BASE_HI: begin
                     base_hi_in   = q_item.data;
                     rsp_valid_in = 1'b1;
                  end
                  OP_WR_WIN: begin
                     win_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_err_in   = 1'b1;
                  end
               endcase
            end
         end
         S_WIN_RD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = win_q;
               rsp_err_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_DIV: begin
            // row start: base with the in-row offset bits cleared
            // (ROW_BYTES is a power of two)
            addr_in  = {1'b0, base_fa & ~FA_W'(ROW_BYTES - 1)};
            idx_in   = '0;
            pend_in  = 1'b0;
            state_in = is_load_ff ? S_LOAD : S_STORE;
         end
         S_LOAD, S_STORE: begin
            // issue read for this byte, finish write of the previous one
            if (state_ff == S_LOAD) begin
               flash_re = !addr_oob;
            end else begin
               win_re    = 1'b1;
               win_raddr = idx_ff;
            end
            pend_in      = 1'b1;
            pend_idx_in  = idx_ff;
            pend_addr_in = addr_ff[FA_W-1:0];
            pend_oob_in  = addr_oob;
            addr_in      = addr_ff + 1'b1;
            if (idx_ff == IDX_W'(ROW_BYTES - 1)) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            pend_in  = 1'b0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 8'h00;
               rsp_err_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // write-back of the pending copy byte
      if (pend_ff && (state_ff == S_LOAD || state_ff == S_STORE || state_ff == S_DRAIN)) begin
         if (is_load_ff) begin
            win_we    = 1'b1;
            win_waddr = pend_idx_ff;
            win_wdata = pend_oob_ff ? ERASED_BYTE : flash_rd_ff;
         end else begin
            flash_we    = !pend_oob_ff;
            flash_waddr = pend_addr_ff;
            flash_wdata = win_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         base_lo_ff   <= '0;
         base_hi_ff   <= '0;
         cmd_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         base_lo_ff   <= base_lo_in;
         base_hi_ff   <= base_hi_in;
         cmd_ff       <= cmd_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (win_we) begin
            win_vld_ff[win_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      is_load_ff   <= is_load_in;
      addr_ff      <= addr_in;
      idx_ff       <= idx_in;
      pend_idx_ff  <= pend_idx_in;
      pend_addr_ff <= pend_addr_in;
      pend_oob_ff  <= pend_oob_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_waddr] <= win_wdata;
      end
      if (win_re) begin
         win_rd_ff     <= win_mem[win_raddr];
         win_rd_vld_ff <= win_vld_ff[win_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (flash_we) begin
         flash_mem[flash_waddr] <= flash_wdata;
      end
      if (flash_re) begin
         flash_rd_ff <= flash_mem[flash_raddr];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_data    = rsp_data_ff;
   assign rsp_chan.access_error = rsp_err_ff;

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !pop)
      else $error("queue popped during flash clear");

   a_cmd_starts_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && pop && q_item.op == OP_WR_CMD && cmd_ok && base_ok)
      |=> (state_ff == S_DIV))
      else $error("valid command did not start row alignment");

   a_slot_empty_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !rsp_valid_ff)
      else $error("response pending while a command runs");

   a_no_item_while_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response produced during flash clear");

endmodule

/* tb/row_buffer_checker.sv */
// Checker for the register-mapped flash row buffer: watches the request, response
// and csr channels, keeps its own copy of the register map and flash, compares replies.
// Depends on rmfrb_pkg and the channel interfaces in rmfrb_if.sv.
module row_buffer_checker
   import rmfrb_pkg::*;
#(
   parameter int ROW_BYTES   = 32,
   parameter int FLASH_BYTES = 128
) (
   input  logic  clock,
   input  logic  reset,
   rmfrb_req_if  req_mon,
   rmfrb_rsp_if  rsp_mon,
   rmfrb_csr_if  csr_mon,
   output int    fail_count,
   output int    outstanding
);

   typedef struct {
      logic [7:0] read_data;
      logic       access_error;
   } reply_type;

   reply_type  pending_replies[$];
   logic [7:0] board_kind, firmware_version, hardware_version;
   logic [7:0] base_low, base_high, last_command;
   logic [7:0] row_window [ROW_BYTES];
   logic [7:0] flash_bytes [FLASH_BYTES];
   int         errors = 0;

   // load or store one row; returns 1 on a bad command or base
   function automatic logic run_row_command(logic [7:0] cmd);
      int unsigned base;
      int unsigned start;
      int unsigned addr;
      base = {base_high, base_low};
      if (cmd != CMD_LOAD && cmd != CMD_STORE) return 1'b1;
      if (base >= FLASH_BYTES) return 1'b1;
      start = base - (base % ROW_BYTES);
      for (int i = 0; i < ROW_BYTES; i++) begin
         addr = start + i;
         if (cmd == CMD_LOAD) begin
            row_window[i] = (addr < FLASH_BYTES) ? flash_bytes[addr] : ERASED_BYTE;
         end else if (addr < FLASH_BYTES) begin
            flash_bytes[addr] = row_window[i];
         end
      end
      return 1'b0;
   endfunction

   function automatic reply_type model_register_access(logic is_write, logic [7:0] addr,
                                                       logic [7:0] data);
      reply_type r;
      logic      in_window;
      r.read_data    = 8'h00;
      r.access_error = 1'b0;
      in_window = (addr >= REG_WINDOW) && (int'(addr) < int'(REG_WINDOW) + ROW_BYTES);
      if (is_write == REQ_READ) begin
         case (addr)
            REG_BOARD:   r.read_data = board_kind;
            REG_FW:      r.read_data = firmware_version;
            REG_HW:      r.read_data = hardware_version;
            REG_CMD:     r.read_data = last_command;
            REG_BASE_LO: r.read_data = base_low;
            REG_BASE_HI: r.read_data = base_high;
            default: begin
               if (in_window) r.read_data = row_window[addr - REG_WINDOW];
               else r.access_error = 1'b1;
            end
         endcase
      end else begin
         case (addr)
            REG_CMD: begin
               last_command   = data;
               r.access_error = run_row_command(data);
            end
            REG_BASE_LO: base_low  = data;
            REG_BASE_HI: base_high = data;
            default: begin
               // read-only ids and unmapped registers land here
               if (in_window) row_window[addr - REG_WINDOW] = data;
               else r.access_error = 1'b1;
            end
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         board_kind       = BOARD_KIND_RESET;
         firmware_version = FIRMWARE_VERSION_RESET;
         hardware_version = HARDWARE_VERSION_RESET;
         base_low         = 8'h00;
         base_high        = 8'h00;
         last_command     = 8'h00;
         for (int i = 0; i < ROW_BYTES; i++) row_window[i] = 8'h00;
         for (int i = 0; i < FLASH_BYTES; i++) flash_bytes[i] = ERASED_BYTE;
         pending_replies.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_BOARD_KIND:       board_kind       = csr_mon.wdata;
               CSR_FIRMWARE_VERSION: firmware_version = csr_mon.wdata;
               CSR_HARDWARE_VERSION: hardware_version = csr_mon.wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_replies.size() == 0) begin
               $display("%0t: reply with none pending: read_data %02h access_error %0b",
                        $time, rsp_mon.read_data, rsp_mon.access_error);
               errors++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_mon.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %02h actual %02h",
                           $time, want.read_data, rsp_mon.read_data);
                  errors++;
               end
               if (rsp_mon.access_error !== want.access_error) begin
                  $display("%0t: access_error expected %0b actual %0b",
                           $time, want.access_error, rsp_mon.access_error);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_replies.push_back(model_register_access(req_mon.req_type,
                                      req_mon.reg_address, req_mon.write_data));
         end
      end
      fail_count  <= errors;
      outstanding <= pending_replies.size();
   end

endmodule

/* tb/tb.sv */
// Top of the row buffer testbench: clock, reset, stimulus, receiver stalls, watchdog.
// Instantiates the block and row_buffer_checker; uses rmfrb_pkg and rmfrb_if.sv.
module tb;
   import rmfrb_pkg::*;

   localparam int ROW_BYTES   = 32;
   localparam int FLASH_BYTES = 128;
   localparam int STALL_LIMIT = 4000;   // cycles with no item moving on any channel
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off, fills the block
   localparam int PHASE_ITEMS = 285;    // random items per idling phase

   logic clock;
   logic reset;

   rmfrb_req_if req_bus ();
   rmfrb_rsp_if rsp_bus ();
   rmfrb_csr_if csr_bus ();

   int fail_count;
   int outstanding;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int idle_cycles = 0;
   logic rsp_hold = 1'b0;
   logic holdoff_armed = 1'b0;

   register_mapped_flash_row_buffer #(
      .ROW_BYTES  (ROW_BYTES),
      .FLASH_BYTES(FLASH_BYTES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   row_buffer_checker #(
      .ROW_BYTES  (ROW_BYTES),
      .FLASH_BYTES(FLASH_BYTES)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: ready is redrawn every falling edge; the hold flag overrides it.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long hold-off: once armed (no-idle phase), the receiver goes deaf for a
   // fixed stretch while the sender keeps pushing, so the block backs up and
   // drops req ready. Flag moves on the rising edge, read on the falling one.
   initial begin
      wait (holdoff_armed);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Watchdog: any cycle with no handshake on any channel counts toward the limit.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // One register access. Called at a falling edge, returns at a falling edge;
   // valid stays high into the next item unless a gap is drawn.
   task automatic send_access(input logic kind, input logic [7:0] addr,
                              input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.req_type    = kind;
      req_bus.reg_address = addr;
      req_bus.write_data  = data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Drain: stop offering items and wait until every reply has come back.
   task automatic wait_until_drained();
      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // csr writes only happen with the block drained.
   task automatic write_setting(input logic [7:0] index, input logic [7:0] value);
      wait_until_drained();
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.wdata = value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic write_all_settings(input logic [7:0] kind_v, input logic [7:0] fw_v,
                                     input logic [7:0] hw_v);
      write_setting(CSR_BOARD_KIND, kind_v);
      write_setting(CSR_FIRMWARE_VERSION, fw_v);
      write_setting(CSR_HARDWARE_VERSION, hw_v);
   endtask

   // Mostly well-formed driver traffic: window fills and reads, register reads, in-range
   // bases, load and store commands. The rest is broken bases, bad commands and pure noise.
   task automatic send_random_access();
      int         pick;
      logic       kind;
      logic [7:0] addr;
      logic [7:0] data;
      pick = $urandom_range(99);
      data = 8'($urandom_range(255));
      kind = REQ_WRITE;
      if (pick < 30) begin
         addr = REG_WINDOW + 8'($urandom_range(ROW_BYTES - 1));
      end else if (pick < 50) begin
         kind = REQ_READ;
         addr = REG_WINDOW + 8'($urandom_range(ROW_BYTES - 1));
      end else if (pick < 60) begin
         addr = REG_BASE_LO;
         if ($urandom_range(3) != 0) data = 8'($urandom_range(FLASH_BYTES - 1));
      end else if (pick < 65) begin
         addr = REG_BASE_HI;
         if ($urandom_range(4) != 0) data = 8'h00;   // keep base mostly in range
      end else if (pick < 77) begin
         addr = REG_CMD;
         if ($urandom_range(5) != 0) data = $urandom_range(1) ? CMD_LOAD : CMD_STORE;
      end else if (pick < 85) begin
         kind = REQ_READ;
         case ($urandom_range(5))
            0: addr = REG_BOARD;
            1: addr = REG_FW;
            2: addr = REG_HW;
            3: addr = REG_CMD;
            4: addr = REG_BASE_LO;
            default: addr = REG_BASE_HI;
         endcase
      end else begin
         kind = 1'($urandom_range(1));
         addr = 8'($urandom_range(255));
      end
      send_access(kind, addr, data);
   endtask

   initial begin
      // every input known from time zero
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = REQ_READ;
      req_bus.reg_address = 8'h00;
      req_bus.write_data  = 8'h00;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = 8'h00;
      csr_bus.wdata       = 8'h00;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // phase 1 idling also covers the directed items
      send_idle_pct = 9;
      recv_idle_pct = 88;

      // --- directed: reset ids, erased state, error paths, both commands ---
      send_access(REQ_READ, REG_BOARD, 8'hFF);
      send_access(REQ_READ, REG_FW, 8'h00);
      send_access(REQ_READ, REG_HW, 8'h00);
      send_access(REQ_READ, REG_CMD, 8'h00);
      send_access(REQ_READ, REG_WINDOW, 8'h00);           // window starts zeroed
      send_access(REQ_READ, 8'h03, 8'h00);                // unknown register read
      send_access(REQ_READ, 8'hFF, 8'hFF);
      send_access(REQ_WRITE, REG_BOARD, 8'hAA);           // read-only id register
      send_access(REQ_WRITE, 8'h40, 8'h55);               // just past the window
      send_access(REQ_WRITE, REG_CMD, CMD_LOAD);          // load erased row 0
      send_access(REQ_READ, REG_WINDOW + 8'd31, 8'h00);
      send_access(REQ_WRITE, REG_WINDOW, 8'hA5);
      send_access(REQ_WRITE, REG_WINDOW + 8'd31, 8'h5A);
      send_access(REQ_WRITE, REG_BASE_LO, 8'h7F);         // unaligned, rounds to 0x60
      send_access(REQ_WRITE, REG_CMD, CMD_STORE);
      send_access(REQ_WRITE, REG_BASE_LO, 8'h80);         // base == flash size
      send_access(REQ_WRITE, REG_CMD, CMD_LOAD);
      send_access(REQ_WRITE, REG_BASE_LO, 8'h60);
      send_access(REQ_WRITE, REG_BASE_HI, 8'hFF);         // far out of range
      send_access(REQ_WRITE, REG_CMD, CMD_STORE);
      send_access(REQ_READ, REG_BASE_HI, 8'h00);
      send_access(REQ_WRITE, REG_BASE_HI, 8'h00);
      send_access(REQ_WRITE, REG_CMD, 8'hFF);             // unknown command, kept
      send_access(REQ_READ, REG_CMD, 8'h00);
      send_access(REQ_WRITE, REG_CMD, CMD_LOAD);          // row 0x60 back in window

      // extremes of the id registers
      write_all_settings(8'h00, 8'hFF, 8'h80);

      // --- random, phase 1: slow receiver ---
      repeat (PHASE_ITEMS) send_random_access();
      write_all_settings(8'hFF, 8'h00, 8'h7F);

      // --- random, phase 2: slow sender ---
      send_idle_pct = 88;
      recv_idle_pct = 9;
      repeat (PHASE_ITEMS) send_random_access();
      write_all_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));

      // --- random, phase 3: no idling, with the long hold-off ---
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holdoff_armed = 1'b1;
      repeat (PHASE_ITEMS) send_random_access();

      // all items in; let the replies drain and give the block time to go quiet
      wait_until_drained();
      repeat (60) @(negedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
